// ===== hw/rtl/itap_pkg.sv =====
// Shared types, character constants and the digit-to-character function.
package itap_pkg;

    typedef enum logic [1:0] {
        KIND_UDEC   = 2'd0,
        KIND_HEX_LO = 2'd1,
        KIND_HEX_UP = 2'd2,
        KIND_SDEC   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic put_sign;
        logic put_digit;
        logic advance;
    } itap_cmd_t;

    typedef struct packed {
        logic in_dec;
        logic last_step;
        logic neg;
        logic emit_now;
        logic at_last;
        logic out_free;
    } itap_status_t;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [3:0] DIGIT_TEN    = 4'd10;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] alpha;
        alpha = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d >= DIGIT_TEN)
        begin
            return alpha + {4'd0, d - DIGIT_TEN};
        end
        return CHAR_ZERO + {4'd0, d};
    endfunction

endpackage

// ===== hw/rtl/itap_in_if.sv =====
// Input channel interface: conversion kind, value and pad width.
interface itap_in_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [VALUE_WIDTH-1:0] value;
    logic [5:0]             pad_width;

    modport source (output valid, output kind, output value, output pad_width, input ready);
    modport sink   (input valid, input kind, input value, input pad_width, output ready);
endinterface

// ===== hw/rtl/itap_out_if.sv =====
// Output channel interface: one ASCII character and its end-of-run mark.
interface itap_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

// ===== hw/rtl/itap_ctrl.sv =====
// Controller state machine: sequences load, conversion, sign and character emission.
module itap_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  itap_pkg::itap_status_t status,
    output itap_pkg::itap_cmd_t    cmd
);
    import itap_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_dec ? ST_CONVERT : ST_EMIT;
                end
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.put_sign = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Suppressed leading zeros are skipped without touching the output.
                if (!status.emit_now)
                begin
                    cmd.advance = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.put_digit = 1'b1;
                    cmd.advance   = 1'b1;
                    if (status.at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/itap_datapath.sv =====
// Datapath: magnitude and sign, BCD conversion, digit store and output register.
module itap_datapath #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_PAD     = 63
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  itap_pkg::itap_cmd_t    cmd,
    output itap_pkg::itap_status_t status,
    input  logic [1:0]             kind,
    input  logic [VALUE_WIDTH-1:0] value,
    input  logic [5:0]             pad_width,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [7:0]             char_out,
    output logic                   last
);
    import itap_pkg::*;

    localparam int HEX_DIG = (VALUE_WIDTH + 3) / 4;
    localparam int SH_W    = HEX_DIG * 4;
    localparam int STEPS   = HEX_DIG;
    localparam int DEC_DIG = (VALUE_WIDTH * 30103 + 99999) / 100000;
    localparam int NDIG    = (DEC_DIG > HEX_DIG) ? DEC_DIG : HEX_DIG;
    localparam int ST_W    = NDIG * 4;
    localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [5:0] POS_NDIG  = 6'(NDIG);
    localparam logic [5:0] PAD_LIMIT = 6'(MAX_PAD);

    logic [ST_W-1:0]   store_reg;
    logic [ST_W-1:0]   store_next;
    logic [SH_W-1:0]   shift_reg;
    logic [SH_W-1:0]   shift_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [5:0]        pos_reg;
    logic [5:0]        pos_next;
    logic [5:0]        pad_reg;
    logic [5:0]        pad_next;
    logic              seen_reg;
    logic              seen_next;
    logic              neg_reg;
    logic              neg_next;
    logic              upper_reg;
    logic              upper_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        char_reg;
    logic [7:0]        char_next;
    logic              last_reg;
    logic              last_next;

    kind_t             kind_in;
    logic              in_dec;
    logic              in_neg;
    logic [31:0]       mag32;
    logic [SH_W-1:0]   load_shift;
    logic [5:0]        pad_sat;
    logic [5:0]        pos_start;
    logic [3:0]        top_digit;
    logic [3:0]        cur_digit;
    logic              in_store;
    logic              emit_now;
    logic [ST_W-1:0]   dab_store;
    logic [SH_W-1:0]   dab_shift;

    // Load-time decode of the incoming item.
    always_comb
    begin
        kind_in    = kind_t'(kind);
        in_dec     = (kind_in == KIND_UDEC) || (kind_in == KIND_SDEC);
        in_neg     = (kind_in == KIND_SDEC) && value[31];
        mag32      = in_neg ? (~value[31:0] + 32'd1) : value[31:0];
        load_shift = (kind_in == KIND_SDEC) ? SH_W'(mag32) : SH_W'(value);
        pad_sat    = (pad_width > PAD_LIMIT) ? PAD_LIMIT : pad_width;
        pos_start  = (pad_sat > POS_NDIG) ? (pad_sat - 6'd1) : (POS_NDIG - 6'd1);
    end

    // Four double-dabble bit steps per cycle: add three to every digit above four, then shift.
    always_comb
    begin
        dab_store = store_reg;
        dab_shift = shift_reg;
        for (int j = 0; j < 4; j++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (dab_store[d*4 +: 4] >= 4'd5)
                begin
                    dab_store[d*4 +: 4] = dab_store[d*4 +: 4] + 4'd3;
                end
            end
            {dab_store, dab_shift} = {dab_store[ST_W-2:0], dab_shift, 1'b0};
        end
    end

    // Position counts down over the printed field; positions at or above the store are padding.
    always_comb
    begin
        top_digit = store_reg[ST_W-1 -: 4];
        in_store  = (pos_reg < POS_NDIG);
        cur_digit = in_store ? top_digit : 4'd0;
        emit_now  = !in_store || seen_reg || (pos_reg < pad_reg) ||
                    (top_digit != 4'd0) || (pos_reg == 6'd0);
    end

    always_comb
    begin
        store_next     = store_reg;
        shift_next     = shift_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        pad_next       = pad_reg;
        seen_next      = seen_reg;
        neg_next       = neg_reg;
        upper_next     = upper_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (cmd.load)
        begin
            store_next = in_dec ? '0 : ST_W'(load_shift);
            shift_next = load_shift;
            step_next  = '0;
            pos_next   = pos_start;
            pad_next   = pad_sat;
            seen_next  = 1'b0;
            neg_next   = in_neg;
            upper_next = (kind_in == KIND_HEX_UP);
        end
        if (cmd.step)
        begin
            store_next = dab_store;
            shift_next = dab_shift;
            step_next  = step_reg + STEP_W'(1);
        end
        if (cmd.advance)
        begin
            if (in_store)
            begin
                store_next = {store_reg[ST_W-5:0], 4'd0};
            end
            pos_next  = pos_reg - 6'd1;
            seen_next = seen_reg || emit_now;
        end

        if (cmd.put_sign)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_MINUS;
            last_next      = 1'b0;
        end
        else if (cmd.put_digit)
        begin
            out_valid_next = 1'b1;
            char_next      = digit_char(cur_digit, upper_reg);
            last_next      = (pos_reg == 6'd0);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        shift_reg <= shift_next;
        pad_reg   <= pad_next;
        neg_reg   <= neg_next;
        upper_reg <= upper_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign status.in_dec    = in_dec;
    assign status.last_step = (step_reg == STEP_W'(STEPS - 1));
    assign status.neg       = neg_reg;
    assign status.emit_now  = emit_now;
    assign status.at_last   = (pos_reg == 6'd0);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_padded_top.sv =====
// Top level: integer to padded ASCII text converter, one character per output item.
// Sequence: a load, double-dabble conversion of the value (decimal kinds only), a
// sign character when negative, then one digit position after another, max(pad, 20) at VALUE_WIDTH 64.
// A new item is taken only once the run of the last one is done; output stalls hold the
// emission.
// Reset: rst_n asynchronously clears the state machine and output valid; no clearing pass.
module integer_to_ascii_padded_top #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_PAD     = 63
) (
    input logic     clk,
    input logic     rst_n,
    itap_in_if.sink in_ch,
    itap_out_if.source out_ch
);
    import itap_pkg::*;

    itap_cmd_t    cmd;
    itap_status_t status;
    logic         in_ready;

    itap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itap_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_PAD     (MAX_PAD)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (in_ch.kind),
        .value     (in_ch.value),
        .pad_width (in_ch.pad_width),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .char_out  (out_ch.char_out),
        .last      (out_ch.last)
    );

    assign in_ch.ready = in_ready;

    // An accepted item takes the block out of idle, so input ready is low right after the accept.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input ready right after an accepted item");

    // A character that is not the end of its run means the item is still in progress.
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.last |-> !in_ch.ready)
        else $error("input ready while an item's run is unfinished");

    // The minus sign always leads a run and is never its final character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && (out_ch.char_out == CHAR_MINUS) |-> !out_ch.last)
        else $error("minus sign marked as last character");

endmodule
